@@ hw/rtl/qcid_pkg.sv @@
// shared types and constants for the quic connection id extractor
package qcid_pkg;

    localparam int MaxIdBytes = 20;

    localparam logic [1:0] KIND_DEST   = 2'd0;
    localparam logic [1:0] KIND_SRC    = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    localparam logic [7:0] FORM_BIT = 8'h80;
    localparam logic [7:0] QUIC_BIT = 8'h40;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_ILLEGAL = 1'b1;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] cid_byte;
        logic       finished;
        logic       status;
        logic       header_form;
        logic [4:0] dest_id_length;
        logic [4:0] source_id_length;
    } t_result;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

endpackage

@@ hw/rtl/quic_connection_id_extractor.sv @@
// top level of the quic connection id extractor
// takes a datagram one byte per item and returns the destination and source
// connection id bytes of its invariant header, one result item per id byte,
// plus a finish item where no byte goes with the end of parsing (rejected
// first byte, zero-length id, early end, length above MAX_ID_BYTES). every
// result carries the header form and the id lengths known so far; exactly one
// result per packet has finished set, and bytes after it are dropped until the
// last-byte flag. an accepted byte sits in the input register; once the
// result register is free, the parser steps its state and any result lands
// in the output register. one byte is taken every cycle while the output
// side keeps up; a result left waiting holds the byte behind it in the
// input register and drops input ready, so at most two items are held. the
// short-header id length is read when a packet's first byte is parsed.
module quic_connection_id_extractor #(
    parameter int MAX_ID_BYTES = qcid_pkg::MaxIdBytes
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [4:0] i_cfg_short_dcid_length,
    // byte input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_cid_byte,
    output logic       o_finished,
    output logic       o_status,
    output logic       o_header_form,
    output logic [4:0] o_dest_id_length,
    output logic [4:0] o_source_id_length
);

    // short-header destination id length register
    logic [4:0] r_short_len;

    qcid_pkg::t_in_item in_item;
    qcid_pkg::t_in_item stage_item;
    qcid_pkg::t_result  step_result;
    qcid_pkg::t_result  out_result;
    logic               stage_valid;
    logic               out_free;
    logic               take;
    logic               emit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_len <= 5'd0;
        end else if (i_cfg_valid) begin
            r_short_len <= i_cfg_short_dcid_length;
        end
    end

    assign in_item.data_byte = i_data_byte;
    assign in_item.last_byte = i_last_byte;

    // a byte leaves the input register only when the result slot is free,
    // whether or not it makes a result
    assign take = stage_valid && out_free;

    qcid_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    qcid_parse #(
        .MAX_ID_BYTES (MAX_ID_BYTES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (stage_item),
        .i_short_len (r_short_len),
        .o_emit      (emit),
        .o_result    (step_result)
    );

    qcid_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && emit),
        .i_result (step_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_result_kind      = out_result.result_kind;
    assign o_cid_byte         = out_result.cid_byte;
    assign o_finished         = out_result.finished;
    assign o_status           = out_result.status;
    assign o_header_form      = out_result.header_form;
    assign o_dest_id_length   = out_result.dest_id_length;
    assign o_source_id_length = out_result.source_id_length;

endmodule

@@ hw/rtl/qcid_in_stage.sv @@
// input register stage holding one byte item
module qcid_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  qcid_pkg::t_in_item i_item,
    input  logic               i_take,
    output logic               o_valid,
    output qcid_pkg::t_in_item o_item
);

    logic               r_valid;
    qcid_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

@@ hw/rtl/qcid_parse.sv @@
// header parse state and its one-step update
module qcid_parse #(
    parameter int MAX_ID_BYTES = qcid_pkg::MaxIdBytes
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  qcid_pkg::t_in_item i_item,
    input  logic [4:0]         i_short_len,
    output logic               o_emit,
    output qcid_pkg::t_result  o_result
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_SHORTID = 3'd1;
    localparam logic [2:0] PH_VERSION = 3'd2;
    localparam logic [2:0] PH_DLEN    = 3'd3;
    localparam logic [2:0] PH_DCID    = 3'd4;
    localparam logic [2:0] PH_SLEN    = 3'd5;
    localparam logic [2:0] PH_SCID    = 3'd6;
    localparam logic [2:0] PH_DONE    = 3'd7;

    localparam logic [7:0] MaxLen = 8'(MAX_ID_BYTES);

    logic [2:0] r_phase, n_phase;
    logic [4:0] r_cnt, n_cnt;
    logic [4:0] r_dlen, n_dlen;
    logic [4:0] r_slen, n_slen;
    logic       r_long, n_long;

    logic [1:0] kind;
    logic [7:0] cbyte;
    logic       fin;
    logic       st;
    logic [4:0] cnt_inc;
    logic [7:0] b;
    logic       last;
    logic [2:0] end_phase;

    assign b         = i_item.data_byte;
    assign last      = i_item.last_byte;
    assign cnt_inc   = r_cnt + 5'd1;
    assign end_phase = last ? PH_IDLE : PH_DONE;

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_dlen  = r_dlen;
        n_slen  = r_slen;
        n_long  = r_long;
        o_emit  = 1'b0;
        kind    = qcid_pkg::KIND_FINISH;
        cbyte   = 8'd0;
        fin     = 1'b0;
        st      = qcid_pkg::STATUS_OK;
        case (r_phase)
            PH_IDLE: begin
                n_cnt  = 5'd0;
                n_dlen = 5'd0;
                n_slen = 5'd0;
                n_long = 1'b0;
                if ((b & (qcid_pkg::FORM_BIT | qcid_pkg::QUIC_BIT)) == 8'd0) begin
                    o_emit  = 1'b1;
                    fin     = 1'b1;
                    st      = qcid_pkg::STATUS_ILLEGAL;
                    n_phase = end_phase;
                end else if ((b & qcid_pkg::FORM_BIT) == 8'd0) begin
                    n_dlen = i_short_len;
                    if (i_short_len == 5'd0) begin
                        o_emit  = 1'b1;
                        fin     = 1'b1;
                        n_phase = end_phase;
                    end else if (last) begin
                        o_emit  = 1'b1;
                        fin     = 1'b1;
                        st      = qcid_pkg::STATUS_ILLEGAL;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_SHORTID;
                    end
                end else begin
                    n_long = 1'b1;
                    if (last) begin
                        o_emit  = 1'b1;
                        fin     = 1'b1;
                        st      = qcid_pkg::STATUS_ILLEGAL;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_VERSION;
                    end
                end
            end
            PH_SHORTID, PH_SCID: begin
                n_cnt  = cnt_inc;
                o_emit = 1'b1;
                kind   = (r_phase == PH_SCID) ? qcid_pkg::KIND_SRC : qcid_pkg::KIND_DEST;
                cbyte  = b;
                if (cnt_inc == ((r_phase == PH_SCID) ? r_slen : r_dlen)) begin
                    fin     = 1'b1;
                    n_phase = end_phase;
                end else if (last) begin
                    fin     = 1'b1;
                    st      = qcid_pkg::STATUS_ILLEGAL;
                    n_phase = PH_IDLE;
                end
            end
            PH_VERSION: begin
                if (last) begin
                    o_emit  = 1'b1;
                    fin     = 1'b1;
                    st      = qcid_pkg::STATUS_ILLEGAL;
                    n_phase = PH_IDLE;
                end else if (cnt_inc >= 5'd4) begin
                    n_cnt   = 5'd0;
                    n_phase = PH_DLEN;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_DLEN: begin
                if (b > MaxLen || last) begin
                    if (b <= MaxLen) begin
                        n_dlen = b[4:0];
                    end
                    o_emit  = 1'b1;
                    fin     = 1'b1;
                    st      = qcid_pkg::STATUS_ILLEGAL;
                    n_phase = end_phase;
                end else begin
                    n_dlen  = b[4:0];
                    n_cnt   = 5'd0;
                    n_phase = (b == 8'd0) ? PH_SLEN : PH_DCID;
                end
            end
            PH_DCID: begin
                n_cnt  = cnt_inc;
                o_emit = 1'b1;
                kind   = qcid_pkg::KIND_DEST;
                cbyte  = b;
                if (last) begin
                    fin     = 1'b1;
                    st      = qcid_pkg::STATUS_ILLEGAL;
                    n_phase = PH_IDLE;
                end else if (cnt_inc == r_dlen) begin
                    n_cnt   = 5'd0;
                    n_phase = PH_SLEN;
                end
            end
            PH_SLEN: begin
                if (b > MaxLen) begin
                    o_emit  = 1'b1;
                    fin     = 1'b1;
                    st      = qcid_pkg::STATUS_ILLEGAL;
                    n_phase = end_phase;
                end else begin
                    n_slen = b[4:0];
                    n_cnt  = 5'd0;
                    if (b == 8'd0) begin
                        o_emit  = 1'b1;
                        fin     = 1'b1;
                        n_phase = end_phase;
                    end else if (last) begin
                        o_emit  = 1'b1;
                        fin     = 1'b1;
                        st      = qcid_pkg::STATUS_ILLEGAL;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_SCID;
                    end
                end
            end
            PH_DONE: begin
                if (last) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result.result_kind      = kind;
        o_result.cid_byte         = cbyte;
        o_result.finished         = fin;
        o_result.status           = fin ? st : qcid_pkg::STATUS_OK;
        o_result.header_form      = n_long;
        o_result.dest_id_length   = n_dlen;
        o_result.source_id_length = n_slen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= 5'd0;
            r_dlen  <= 5'd0;
            r_slen  <= 5'd0;
            r_long  <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_dlen  <= n_dlen;
            r_slen  <= n_slen;
            r_long  <= n_long;
        end
    end

endmodule

@@ hw/rtl/qcid_out_stage.sv @@
// result register toward the output channel
module qcid_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  qcid_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output qcid_pkg::t_result o_result
);

    logic              r_valid;
    qcid_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ dv/quic_connection_id_extractor_tb.sv @@
// self-checking testbench for the quic connection id extractor
module quic_connection_id_extractor_tb;

    // run limits
    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_LEN   = 12;    // settle time after the owed results are drained
    localparam int HOLD_LEN     = 300;   // long receiver hold-off
    localparam int PHASE_BYTES  = 85;    // random bytes per idling phase

    // parser phases of the byte-level model
    typedef enum logic [2:0] {
        WAIT_FIRST,
        SHORT_ID,
        VERSION_SKIP,
        DEST_LEN,
        DEST_ID,
        SRC_LEN,
        SRC_ID,
        TRAILER
    } t_parse_phase;

    // clock, reset and block inputs, all known from time zero
    logic       i_clk                   = 1'b0;
    logic       i_rst_n                 = 1'b0;
    logic       i_cfg_valid             = 1'b0;
    logic [4:0] i_cfg_short_dcid_length = '0;
    logic       i_in_valid              = 1'b0;
    logic [7:0] i_data_byte             = '0;
    logic       i_last_byte             = 1'b0;
    logic       i_out_ready             = 1'b0;

    logic       o_cfg_ready;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_result_kind;
    logic [7:0] o_cid_byte;
    logic       o_finished;
    logic       o_status;
    logic       o_header_form;
    logic [4:0] o_dest_id_length;
    logic [4:0] o_source_id_length;

    // parser model state, mirrors the block after reset
    t_parse_phase parser_phase  = WAIT_FIRST;
    logic [4:0]   id_count      = '0;
    logic [4:0]   dest_len      = '0;
    logic [4:0]   src_len       = '0;
    logic         long_form     = 1'b0;
    logic [4:0]   short_len_cfg = '0;

    // id results still owed by the block, oldest first
    qcid_pkg::t_result expected_cids[$];
    logic [7:0]        packet[$];

    int failures         = 0;
    int cycles           = 0;
    int bytes_sent       = 0;
    int sender_idle_pct  = 0;
    int receiver_stall_pct = 0;
    int hold_asked       = 0;
    int hold_taken       = 0;
    int hold_left        = 0;

    quic_connection_id_extractor dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_short_dcid_length(i_cfg_short_dcid_length),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_data_byte            (i_data_byte),
        .i_last_byte            (i_last_byte),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_result_kind          (o_result_kind),
        .o_cid_byte             (o_cid_byte),
        .o_finished             (o_finished),
        .o_status               (o_status),
        .o_header_form          (o_header_form),
        .o_dest_id_length       (o_dest_id_length),
        .o_source_id_length     (o_source_id_length)
    );

    always #1 i_clk = ~i_clk;

    // watchdog: a hung handshake or a lost result ends here
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result-side ready: random stalls, plus a long hold-off when one is asked for
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_taken != hold_asked) begin
            i_out_ready <= 1'b0;
            hold_left   <= HOLD_LEN;
            hold_taken  <= hold_taken + 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // compare every accepted result with the oldest one owed
    always @(posedge i_clk) begin : result_check
        qcid_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_cids.size() == 0) begin
                $error("result with none expected: kind %0d byte %0d",
                       o_result_kind, o_cid_byte);
                failures++;
            end else begin
                want = expected_cids.pop_front();
                check_field("result_kind", want.result_kind, o_result_kind);
                check_field("cid_byte", want.cid_byte, o_cid_byte);
                check_field("finished", want.finished, o_finished);
                check_field("status", want.status, o_status);
                check_field("header_form", want.header_form, o_header_form);
                check_field("dest_id_length", want.dest_id_length, o_dest_id_length);
                check_field("source_id_length", want.source_id_length,
                            o_source_id_length);
            end
        end
    end

    // byte-level parser model: updates the state and tells whether a result is owed
    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output qcid_pkg::t_result r);
        bit         emit;
        logic [1:0] kind;
        logic [7:0] id_byte;
        logic       fin;
        logic       stat;
        emit    = 1'b0;
        kind    = qcid_pkg::KIND_FINISH;
        id_byte = '0;
        fin     = 1'b0;
        stat    = qcid_pkg::STATUS_OK;
        case (parser_phase)
            WAIT_FIRST: begin
                id_count  = '0;
                dest_len  = '0;
                src_len   = '0;
                long_form = 1'b0;
                if ((b & (qcid_pkg::FORM_BIT | qcid_pkg::QUIC_BIT)) == '0) begin
                    // neither form nor fixed bit: rejected
                    fin  = 1'b1;
                    stat = qcid_pkg::STATUS_ILLEGAL;
                end else if ((b & qcid_pkg::FORM_BIT) == '0) begin
                    dest_len = short_len_cfg;
                    if (dest_len == '0) begin
                        fin = 1'b1;
                    end else if (last) begin
                        fin  = 1'b1;
                        stat = qcid_pkg::STATUS_ILLEGAL;
                    end else begin
                        parser_phase = SHORT_ID;
                    end
                end else begin
                    long_form = 1'b1;
                    if (last) begin
                        fin  = 1'b1;
                        stat = qcid_pkg::STATUS_ILLEGAL;
                    end else begin
                        parser_phase = VERSION_SKIP;
                    end
                end
                emit = fin;
            end
            SHORT_ID: begin
                id_count = id_count + 5'd1;
                emit     = 1'b1;
                kind     = qcid_pkg::KIND_DEST;
                id_byte  = b;
                if (id_count == dest_len) begin
                    fin = 1'b1;
                end else if (last) begin
                    fin  = 1'b1;
                    stat = qcid_pkg::STATUS_ILLEGAL;
                end
            end
            VERSION_SKIP: begin
                if (last) begin
                    emit = 1'b1;
                    fin  = 1'b1;
                    stat = qcid_pkg::STATUS_ILLEGAL;
                end else begin
                    id_count = id_count + 5'd1;
                    if (id_count >= 5'd4) begin
                        id_count     = '0;
                        parser_phase = DEST_LEN;
                    end
                end
            end
            DEST_LEN: begin
                if (b > qcid_pkg::MaxIdBytes || last) begin
                    // an oversized length is reported as zero
                    if (b <= qcid_pkg::MaxIdBytes) dest_len = b[4:0];
                    emit = 1'b1;
                    fin  = 1'b1;
                    stat = qcid_pkg::STATUS_ILLEGAL;
                end else begin
                    dest_len     = b[4:0];
                    id_count     = '0;
                    parser_phase = (b == '0) ? SRC_LEN : DEST_ID;
                end
            end
            DEST_ID: begin
                id_count = id_count + 5'd1;
                emit     = 1'b1;
                kind     = qcid_pkg::KIND_DEST;
                id_byte  = b;
                if (last) begin
                    // source length byte still missing
                    fin  = 1'b1;
                    stat = qcid_pkg::STATUS_ILLEGAL;
                end else if (id_count == dest_len) begin
                    id_count     = '0;
                    parser_phase = SRC_LEN;
                end
            end
            SRC_LEN: begin
                emit = 1'b1;
                if (b > qcid_pkg::MaxIdBytes) begin
                    fin  = 1'b1;
                    stat = qcid_pkg::STATUS_ILLEGAL;
                end else begin
                    src_len  = b[4:0];
                    id_count = '0;
                    if (b == '0) begin
                        fin = 1'b1;
                    end else if (last) begin
                        fin  = 1'b1;
                        stat = qcid_pkg::STATUS_ILLEGAL;
                    end else begin
                        emit         = 1'b0;
                        parser_phase = SRC_ID;
                    end
                end
            end
            SRC_ID: begin
                id_count = id_count + 5'd1;
                emit     = 1'b1;
                kind     = qcid_pkg::KIND_SRC;
                id_byte  = b;
                if (id_count == src_len) begin
                    fin = 1'b1;
                end else if (last) begin
                    fin  = 1'b1;
                    stat = qcid_pkg::STATUS_ILLEGAL;
                end
            end
            default: begin
                // trailing bytes are dropped until the last flag
                if (last) parser_phase = WAIT_FIRST;
            end
        endcase
        if (fin) parser_phase = last ? WAIT_FIRST : TRAILER;
        r.result_kind      = kind;
        r.cid_byte         = id_byte;
        r.finished         = fin;
        r.status           = fin ? stat : qcid_pkg::STATUS_OK;
        r.header_form      = long_form;
        r.dest_id_length   = dest_len;
        r.source_id_length = src_len;
        return emit;
    endfunction

    // offer one byte, wait for it to be taken, then record what it owes
    task automatic send_byte(input logic [7:0] b, input logic last);
        qcid_pkg::t_result want;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
        if (parse_byte(b, last, want)) expected_cids.push_back(want);
        bytes_sent++;
    endtask

    task automatic send_packet();
        foreach (packet[i]) send_byte(packet[i], i == packet.size() - 1);
    endtask

    // stop offering and let every owed result come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_cids.size() != 0) @(posedge i_clk);
        repeat (SETTLE_LEN) @(posedge i_clk);
    endtask

    // register writes only with the block drained and between packets
    task automatic set_short_len(input logic [4:0] len);
        drain_results();
        i_cfg_valid             <= 1'b1;
        i_cfg_short_dcid_length <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        short_len_cfg = len;
    endtask

    // mostly small ids, sometimes anything up to the maximum
    function automatic int pick_id_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(0, 4);
        if (r < 8) return $urandom_range(0, qcid_pkg::MaxIdBytes);
        return qcid_pkg::MaxIdBytes;
    endfunction

    // well-formed headers with random content, plus rejected, oversized,
    // truncated and pure-noise packets
    task automatic build_random_packet();
        int  shape;
        int  dlen;
        int  slen;
        int  cut;
        bit  is_long;
        shape   = $urandom_range(0, 99);
        dlen    = pick_id_len();
        slen    = pick_id_len();
        is_long = $urandom_range(0, 1);
        packet  = {};
        if (shape >= 92) begin
            repeat ($urandom_range(1, 8)) packet.push_back(8'($urandom));
            return;
        end
        if (is_long) begin
            packet.push_back(qcid_pkg::FORM_BIT | 8'($urandom_range(0, 127)));
            repeat (4) packet.push_back(8'($urandom));
            packet.push_back(8'(dlen));
            repeat (dlen) packet.push_back(8'($urandom));
            packet.push_back(8'(slen));
            repeat (slen) packet.push_back(8'($urandom));
        end else begin
            packet.push_back(qcid_pkg::QUIC_BIT | 8'($urandom_range(0, 63)));
            repeat (short_len_cfg) packet.push_back(8'($urandom));
        end
        if (shape < 8) begin
            packet[0] = 8'($urandom_range(0, 63));
        end else if (shape < 16 && is_long) begin
            if ($urandom_range(0, 1)) begin
                packet[5] = 8'($urandom_range(qcid_pkg::MaxIdBytes + 1, 255));
            end else begin
                packet[6 + dlen] = 8'($urandom_range(qcid_pkg::MaxIdBytes + 1, 255));
            end
        end else if (shape < 30) begin
            cut = $urandom_range(1, packet.size());
            while (packet.size() > cut) void'(packet.pop_back());
            return;
        end
        repeat ($urandom_range(0, 3)) packet.push_back(8'($urandom));
    endtask

    // rejected first byte, short header with an empty id, trailing byte
    task automatic test_rejected_and_empty_ids();
        packet = '{8'h00};
        send_packet();
        packet = '{8'h40, 8'hFF};
        send_packet();
    endtask

    // short header: full id, id cut short, packet ending on its first byte
    task automatic test_short_header();
        set_short_len(5'd2);
        packet = '{8'h7F, 8'h00, 8'hFF};
        send_packet();
        packet = '{8'h55, 8'hAA};
        send_packet();
        packet = '{8'h40};
        send_packet();
    endtask

    // long header with fixed bit clear and empty source id, early end inside the
    // version, destination length above the maximum
    task automatic test_long_header();
        packet = '{8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00};
        send_packet();
        packet = '{8'hC3, 8'h11};
        send_packet();
        packet = '{8'hC0, 8'h01, 8'h02, 8'h03, 8'h04, 8'hFF};
        send_packet();
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input logic [4:0] len);
        int start;
        set_short_len(len);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        start              = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES) begin
            build_random_packet();
            send_packet();
        end
    endtask

    // four idling phases, each under its own short id length
    task automatic test_random_traffic();
        run_random_phase(0, 0, 5'd20);
        run_random_phase(72, 0, 5'd31);
        run_random_phase(0, 72, 5'd0);
        run_random_phase(18, 18, 5'($urandom_range(1, 19)));
    endtask

    // receiver holds off for a long stretch while bytes keep coming, so the
    // block fills and stalls its input; then the sender waits for every result
    task automatic test_backpressure();
        int start;
        set_short_len(5'd5);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_asked++;
        start = bytes_sent;
        while (bytes_sent - start < 60) begin
            build_random_packet();
            send_packet();
        end
        drain_results();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_rejected_and_empty_ids();
        test_short_header();
        test_long_header();
        test_random_traffic();
        test_backpressure();
        receiver_stall_pct = 0;
        drain_results();
        if (failures == 0 && expected_cids.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
